[src/bst_pkg.sv]
// Package for the bit-mask similarity table: sizes, op and status codes,
// sequencer states, reset contents and the popcount helper.
// No dependencies.
package bst_pkg;

    // Table geometry
    localparam int ENTRIES   = 16;
    localparam int MASK_BITS = 64;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int POP_W     = $clog2(MASK_BITS + 1);

    // Fixed port field widths
    localparam int OP_W     = 2;
    localparam int ID_W     = 4;
    localparam int MVAL_W   = 64;
    localparam int SCORE_W  = 7;
    localparam int STATUS_W = 2;

    // Number of entries present after reset
    localparam int PRELOAD_CNT = 6;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_QUERY = 2'd1,
        OP_LINK  = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_DONE   = 2'd0,
        STS_ABSENT = 2'd1,
        STS_EMPTY  = 2'd2,
        STS_FULL   = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_Q_RD,
        ST_Q_MINE,
        ST_SCAN,
        ST_L_EVAL,
        ST_L_RDA,
        ST_L_WRA,
        ST_L_RDB,
        ST_L_WRB,
        ST_FINISH
    } seq_state_t;

    typedef logic [MASK_BITS-1:0] mask_t;

    // Mask held by an entry that has not been written since reset
    function automatic mask_t preload_mask(input logic [IDX_W-1:0] idx);
        mask_t m;
        case (int'(idx))
            0:       m = mask_t'(5);
            1:       m = mask_t'(6);
            2:       m = mask_t'(8);
            3:       m = mask_t'(3);
            4:       m = mask_t'(13);
            default: m = '0;
        endcase
        return m;
    endfunction

    // Count of set bits in a mask
    function automatic logic [POP_W-1:0] popcount(input mask_t v);
        logic [POP_W-1:0] n;
        n = '0;
        for (int i = 0; i < MASK_BITS; i++) begin
            n = n + POP_W'(v[i]);
        end
        return n;
    endfunction

endpackage

[src/bitmask_similarity_table_top.sv]
// Top level of the bit-mask similarity table: mask store, presence flags,
// scan sequencer with a single popcount unit and a single OR unit, and output register.
// Depends on bst_pkg.

// One item is handled at a time; s_ready is high only while the sequencer
// is idle. Queries and links are paced by the scan, which reads one entry
// per cycle through the single read port of the mask memory and feeds it to
// the one popcount (query) or OR (link) unit. The result sits in an output
// register, so the next item can be accepted while it waits for m_ready.
// Reset needs no clearing pass; entries 0 to 5 come up present with masks
// 5, 6, 8, 3, 13 and 0.
module bitmask_similarity_table_top
    import bst_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [OP_W-1:0]     s_op,
    input  logic [ID_W-1:0]     s_first_id,
    input  logic [ID_W-1:0]     s_second_id,
    input  logic [MVAL_W-1:0]   s_mask_value,
    input  logic                s_entry_valid,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [ID_W-1:0]     m_result_id,
    output logic [SCORE_W-1:0]  m_score,
    output logic [STATUS_W-1:0] m_status
);

    seq_state_t state_reg, state_next;

    // Latched item
    logic [OP_W-1:0]   op_reg, op_next;
    logic [ID_W-1:0]   a_reg, a_next;
    logic [ID_W-1:0]   b_reg, b_next;
    mask_t             mask_reg, mask_next;
    logic              ev_reg, ev_next;

    // Working registers
    logic [CNT_W-1:0]  idx_reg, idx_next;
    mask_t             mine_reg, mine_next;
    logic [POP_W-1:0]  best_reg, best_next;
    logic [ID_W-1:0]   rid_reg, rid_next;
    status_t           status_reg, status_next;
    mask_t             used_reg, used_next;
    mask_t             bit_reg, bit_next;

    // Entry flags
    logic [ENTRIES-1:0] present_reg, present_next;
    logic [ENTRIES-1:0] written_reg;

    // Output register
    logic                m_valid_reg, m_valid_next;
    logic [ID_W-1:0]     m_result_id_reg, m_result_id_next;
    logic [SCORE_W-1:0]  m_score_reg, m_score_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;

    // Mask memory
    mask_t              mem [ENTRIES];
    logic               mem_we;
    logic [IDX_W-1:0]   mem_wa;
    mask_t              mem_wd;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   rd_addr_q_reg;
    mask_t              rd_q_reg;
    logic               rd_hit_reg;
    mask_t              rdata;

    // Scan helpers
    logic [IDX_W-1:0]   pidx;
    logic [POP_W-1:0]   pop;
    mask_t              free_bits;
    logic               in_accept;

    assign s_ready       = (state_reg == ST_IDLE);
    assign in_accept     = s_valid && s_ready;
    assign m_valid       = m_valid_reg;
    assign m_result_id   = m_result_id_reg;
    assign m_score       = m_score_reg;
    assign m_status      = m_status_reg;

    // Unwritten entries read as their reset contents
    assign rdata     = rd_hit_reg ? rd_q_reg : preload_mask(rd_addr_q_reg);
    assign pidx      = IDX_W'(idx_reg - CNT_W'(1));
    assign pop       = popcount(mine_reg & rdata);
    assign free_bits = ~used_reg;

    // Memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_q_reg      <= mem[rd_addr];
        rd_hit_reg    <= written_reg[rd_addr];
        rd_addr_q_reg <= rd_addr;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            written_reg <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                present_reg[i] <= (i < PRELOAD_CNT);
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            present_reg <= present_next;
            if (mem_we) begin
                written_reg[mem_wa] <= 1'b1;
            end
        end
    end

    // Payload and working registers
    always_ff @(posedge aclk) begin
        op_reg          <= op_next;
        a_reg           <= a_next;
        b_reg           <= b_next;
        mask_reg        <= mask_next;
        ev_reg          <= ev_next;
        idx_reg         <= idx_next;
        mine_reg        <= mine_next;
        best_reg        <= best_next;
        rid_reg         <= rid_next;
        status_reg      <= status_next;
        used_reg        <= used_next;
        bit_reg         <= bit_next;
        m_result_id_reg <= m_result_id_next;
        m_score_reg     <= m_score_next;
        m_status_reg    <= m_status_next;
    end

    // Sequencer
    always_comb begin
        logic a_ok;
        logic b_ok;

        state_next       = state_reg;
        op_next          = op_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        mask_next        = mask_reg;
        ev_next          = ev_reg;
        idx_next         = idx_reg;
        mine_next        = mine_reg;
        best_next        = best_reg;
        rid_next         = rid_reg;
        status_next      = status_reg;
        used_next        = used_reg;
        bit_next         = bit_reg;
        present_next     = present_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_result_id_next = m_result_id_reg;
        m_score_next     = m_score_reg;
        m_status_next    = m_status_reg;
        mem_we           = 1'b0;
        mem_wa           = IDX_W'(a_reg);
        mem_wd           = mask_reg;
        rd_addr          = IDX_W'(a_reg);

        a_ok = (int'(s_first_id) < ENTRIES) && present_reg[IDX_W'(s_first_id)];
        b_ok = (int'(s_second_id) < ENTRIES) && present_reg[IDX_W'(s_second_id)];

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    op_next     = s_op;
                    a_next      = s_first_id;
                    b_next      = s_second_id;
                    mask_next   = s_mask_value[MASK_BITS-1:0];
                    ev_next     = s_entry_valid;
                    idx_next    = '0;
                    best_next   = '0;
                    rid_next    = s_first_id;
                    status_next = STS_DONE;
                    used_next   = '0;
                    case (s_op)
                        OP_WRITE: begin
                            state_next = ST_WRITE;
                        end
                        OP_QUERY: begin
                            if (a_ok) begin
                                state_next = ST_Q_RD;
                            end else begin
                                status_next = STS_ABSENT;
                                state_next  = ST_FINISH;
                            end
                        end
                        OP_LINK: begin
                            if (a_ok && b_ok) begin
                                state_next = ST_SCAN;
                            end else begin
                                status_next = STS_ABSENT;
                                state_next  = ST_FINISH;
                            end
                        end
                        default: begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            // Load or remove one entry
            ST_WRITE: begin
                if (int'(a_reg) < ENTRIES) begin
                    mem_we                     = 1'b1;
                    mem_wa                     = IDX_W'(a_reg);
                    mem_wd                     = ev_reg ? mask_reg : '0;
                    present_next[IDX_W'(a_reg)] = ev_reg;
                end
                state_next = ST_FINISH;
            end

            // Fetch the asked entry's mask
            ST_Q_RD: begin
                rd_addr    = IDX_W'(a_reg);
                state_next = ST_Q_MINE;
            end

            ST_Q_MINE: begin
                mine_next  = rdata;
                idx_next   = '0;
                state_next = ST_SCAN;
            end

            // Walk all entries: issue read idx, process idx-1
            ST_SCAN: begin
                rd_addr  = IDX_W'(idx_reg);
                idx_next = idx_reg + CNT_W'(1);
                if (idx_reg != '0 && present_reg[pidx]) begin
                    if (op_reg == OP_QUERY) begin
                        if (pidx != IDX_W'(a_reg) && pop > best_reg) begin
                            best_next = pop;
                            rid_next  = ID_W'(pidx);
                        end
                    end else begin
                        used_next = used_reg | rdata;
                    end
                end
                if (idx_reg == CNT_W'(ENTRIES)) begin
                    state_next = (op_reg == OP_QUERY) ? ST_FINISH : ST_L_EVAL;
                end
            end

            // Pick the lowest bit no entry uses, or report an empty or full table
            ST_L_EVAL: begin
                if (used_reg == '0) begin
                    status_next = STS_EMPTY;
                    state_next  = ST_FINISH;
                end else if (free_bits == '0) begin
                    status_next = STS_FULL;
                    state_next  = ST_FINISH;
                end else begin
                    bit_next   = free_bits & (~free_bits + mask_t'(1));
                    state_next = ST_L_RDA;
                end
            end

            // Read-modify-write of both linked entries
            ST_L_RDA: begin
                rd_addr    = IDX_W'(a_reg);
                state_next = ST_L_WRA;
            end

            ST_L_WRA: begin
                mem_we     = 1'b1;
                mem_wa     = IDX_W'(a_reg);
                mem_wd     = rdata | bit_reg;
                state_next = ST_L_RDB;
            end

            ST_L_RDB: begin
                rd_addr    = IDX_W'(b_reg);
                state_next = ST_L_WRB;
            end

            ST_L_WRB: begin
                mem_we     = 1'b1;
                mem_wa     = IDX_W'(b_reg);
                mem_wd     = rdata | bit_reg;
                state_next = ST_FINISH;
            end

            // Hand the result to the output register once it is free
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    m_result_id_next = rid_reg;
                    m_score_next     = SCORE_W'(best_reg);
                    m_status_next    = status_reg;
                    state_next       = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[tb/tb_bitmask_similarity_table_top.sv]
// Self-checking testbench for bitmask_similarity_table_top: directed and random
// write/query/link traffic with random gaps on both channels, predicted in-line.
// Depends on bst_pkg and the top level RTL.
module tb_bitmask_similarity_table_top
    import bst_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_PCT      = 38;
    localparam int CALM_FIRST    = 200;
    localparam int CALM_LAST     = 300;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int DRAIN_CYCLES  = 30;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [ID_W-1:0]   first_id;
        logic [ID_W-1:0]   second_id;
        logic [MVAL_W-1:0] mask_value;
        logic              entry_valid;
    } table_req_t;

    typedef struct {
        logic [ID_W-1:0]    result_id;
        logic [SCORE_W-1:0] score;
        status_t            status;
    } table_rsp_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_op;
    logic [ID_W-1:0]     s_first_id;
    logic [ID_W-1:0]     s_second_id;
    logic [MVAL_W-1:0]   s_mask_value;
    logic                s_entry_valid;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [ID_W-1:0]     m_result_id;
    logic [SCORE_W-1:0]  m_score;
    logic [STATUS_W-1:0] m_status;

    table_req_t cur_req = '{OP_WRITE, '0, '0, '0, 1'b0};
    table_req_t pending_reqs[$];
    table_rsp_t expected_rsps[$];

    // Shadow copy of the table
    mask_t model_mask[ENTRIES];
    logic  model_present[ENTRIES];

    bit req_taken = 1'b0;
    int reqs_sent = 0;
    int idle_cycles = 0;
    int error_count = 0;

    assign s_op          = cur_req.op;
    assign s_first_id    = cur_req.first_id;
    assign s_second_id   = cur_req.second_id;
    assign s_mask_value  = cur_req.mask_value;
    assign s_entry_valid = cur_req.entry_valid;

    bitmask_similarity_table_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_first_id    (s_first_id),
        .s_second_id   (s_second_id),
        .s_mask_value  (s_mask_value),
        .s_entry_valid (s_entry_valid),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_id   (m_result_id),
        .m_score       (m_score),
        .m_status      (m_status)
    );

    always #5 aclk = ~aclk;

    // Apply one request to the shadow table and return the response it yields
    function automatic table_rsp_t apply_request(input table_req_t r);
        table_rsp_t rsp;
        mask_t      mine;
        mask_t      used;
        mask_t      free_bits;
        mask_t      new_bit;
        int         shared;
        rsp.result_id = r.first_id;
        rsp.score     = '0;
        rsp.status    = STS_DONE;
        case (r.op)
            OP_WRITE: begin
                model_present[r.first_id] = r.entry_valid;
                model_mask[r.first_id]    = r.entry_valid ? mask_t'(r.mask_value) : '0;
            end
            OP_QUERY: begin
                if (!model_present[r.first_id]) begin
                    rsp.status = STS_ABSENT;
                end else begin
                    mine = model_mask[r.first_id];
                    // strict compare keeps the lowest id on a tie
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (model_present[i] && i != int'(r.first_id)) begin
                            shared = $countones(mine & model_mask[i]);
                            if (shared > int'(rsp.score)) begin
                                rsp.score     = SCORE_W'(shared);
                                rsp.result_id = ID_W'(i);
                            end
                        end
                    end
                end
            end
            OP_LINK: begin
                if (!model_present[r.first_id] || !model_present[r.second_id]) begin
                    rsp.status = STS_ABSENT;
                end else begin
                    used = '0;
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (model_present[i]) used |= model_mask[i];
                    end
                    if (used == '0) begin
                        rsp.status = STS_EMPTY;
                    end else if (&used) begin
                        rsp.status = STS_FULL;
                    end else begin
                        free_bits = ~used;
                        new_bit   = free_bits & (~free_bits + mask_t'(1));
                        model_mask[r.first_id]  |= new_bit;
                        model_mask[r.second_id] |= new_bit;
                    end
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    function automatic mask_t random_mask();
        mask_t m;
        case ($urandom_range(0, 15))
            0:       m = '1;
            1:       m = '0;
            2, 3:    m = {$urandom, $urandom};
            4, 5, 6: m = mask_t'(1) << $urandom_range(0, MASK_BITS - 1);
            default: m = mask_t'($urandom_range(0, 16'hFFFF)) & {$urandom, $urandom};
        endcase
        return m;
    endfunction

    task automatic add_req(input logic [OP_W-1:0] op, input int a, input int b,
                           input mask_t mask, input logic ev);
        table_req_t r;
        r.op          = op;
        r.first_id    = ID_W'(a);
        r.second_id   = ID_W'(b);
        r.mask_value  = mask;
        r.entry_valid = ev;
        pending_reqs.push_back(r);
    endtask

    task automatic mismatch_report(input string msg);
        error_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // No idling on either side during a window of the random part
    function automatic bit calm_window();
        return reqs_sent >= CALM_FIRST && reqs_sent < CALM_LAST;
    endfunction

    // Request driver: next transfer is presented at the falling edge
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || req_taken)) begin
            if (pending_reqs.size() > 0 &&
                (calm_window() || $urandom_range(0, 99) >= IDLE_PCT)) begin
                cur_req <= pending_reqs.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Response back-pressure
    always @(negedge aclk) begin
        m_ready <= calm_window() || $urandom_range(0, 99) >= IDLE_PCT;
    end

    // Monitor: check responses, predict on accepted requests, watchdog
    always @(posedge aclk) begin : monitor
        table_rsp_t exp_rsp;
        bit         rsp_taken;
        req_taken = (s_valid === 1'b1 && s_ready === 1'b1);
        rsp_taken = (m_valid === 1'b1 && m_ready === 1'b1);
        if (rsp_taken) begin
            if (expected_rsps.size() == 0) begin
                mismatch_report($sformatf("response id=%0d score=%0d status=%0d unexpected",
                                          m_result_id, m_score, m_status));
            end else begin
                exp_rsp = expected_rsps.pop_front();
                if (m_result_id !== exp_rsp.result_id)
                    mismatch_report($sformatf("result_id got %0d exp %0d",
                                              m_result_id, exp_rsp.result_id));
                if (m_score !== exp_rsp.score)
                    mismatch_report($sformatf("score got %0d exp %0d",
                                              m_score, exp_rsp.score));
                if (m_status !== exp_rsp.status)
                    mismatch_report($sformatf("status got %0d exp %0d",
                                              m_status, exp_rsp.status));
            end
        end
        if (req_taken) begin
            expected_rsps.push_back(apply_request(cur_req));
            reqs_sent++;
        end
        if (req_taken || rsp_taken) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        // Shadow table reset contents
        for (int i = 0; i < ENTRIES; i++) begin
            model_mask[i]    = '0;
            model_present[i] = 1'b0;
        end
        model_mask[0] = mask_t'(5);
        model_mask[1] = mask_t'(6);
        model_mask[2] = mask_t'(8);
        model_mask[3] = mask_t'(3);
        model_mask[4] = mask_t'(13);
        for (int i = 0; i < PRELOAD_CNT; i++) model_present[i] = 1'b1;

        // Directed: preload query, tie, no sharer, absent ids, links, full/empty
        add_req(OP_QUERY, 0, 7, '0, 1'b0);
        add_req(OP_QUERY, 5, 0, '1, 1'b1);
        add_req(OP_QUERY, 10, 0, '0, 1'b1);
        add_req(OP_LINK, 0, 1, '0, 1'b0);
        add_req(OP_LINK, 0, 9, '0, 1'b0);
        add_req(OP_LINK, 12, 2, '0, 1'b0);
        add_req(OP_LINK, 2, 2, '1, 1'b1);
        add_req(OP_UNUSED, 15, 15, '1, 1'b1);
        add_req(OP_WRITE, 15, 0, '1, 1'b1);
        add_req(OP_QUERY, 15, 0, '0, 1'b0);
        add_req(OP_LINK, 3, 15, '0, 1'b0);
        add_req(OP_WRITE, 15, 3, '1, 1'b0);
        add_req(OP_QUERY, 15, 0, '0, 1'b0);
        for (int i = 0; i < PRELOAD_CNT; i++) add_req(OP_WRITE, i, 15 - i, '0, 1'b1);
        add_req(OP_LINK, 0, 5, '0, 1'b0);
        add_req(OP_QUERY, 0, 0, '0, 1'b0);
        add_req(OP_WRITE, 8, 0, {32{2'b10}}, 1'b1);
        add_req(OP_WRITE, 9, 0, {32{2'b01}}, 1'b1);
        add_req(OP_QUERY, 8, 0, '0, 1'b0);
        add_req(OP_LINK, 8, 9, '0, 1'b0);

        // Random: blocks that start from a cleared table, then mixed traffic
        for (int blk = 0; blk < 4; blk++) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if ($urandom_range(0, 1)) add_req(OP_WRITE, i, $urandom_range(0, 15),
                                                  random_mask(), 1'b0);
                else add_req(OP_WRITE, i, $urandom_range(0, 15), '0, 1'b1);
            end
            for (int n = 0; n < 78; n++) begin
                int sel;
                sel = $urandom_range(0, 99);
                if (sel < 35)
                    add_req(OP_WRITE, $urandom_range(0, 15), $urandom_range(0, 15),
                            random_mask(), $urandom_range(0, 99) < 85);
                else if (sel < 68)
                    add_req(OP_QUERY, $urandom_range(0, 15), $urandom_range(0, 15),
                            {$urandom, $urandom}, 1'($urandom_range(0, 1)));
                else if (sel < 95)
                    add_req(OP_LINK, $urandom_range(0, 15), $urandom_range(0, 15),
                            {$urandom, $urandom}, 1'($urandom_range(0, 1)));
                else
                    add_req(OP_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15),
                            {$urandom, $urandom}, 1'($urandom_range(0, 1)));
            end
        end

        // Reset, then release at a falling edge
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        wait (pending_reqs.size() == 0 && s_valid == 1'b0);
        wait (expected_rsps.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
